FILE: design/sc1a_pkg.sv
// Shared types, scan code constants and translation tables for the scan code decoder.
// No dependencies; used by sc1a_decode and scancode_set1_to_ascii.
`default_nettype none

package sc1a_pkg;

    localparam int unsigned CODE_W = 8;
    localparam int unsigned CHAR_W = 7;
    localparam int unsigned KEY_COUNT = 58;
    localparam int unsigned KEY_IDX_W = 6;

    localparam logic [CODE_W-1:0] CODE_LSHIFT_MAKE = 8'h2A;
    localparam logic [CODE_W-1:0] CODE_RSHIFT_MAKE = 8'h36;
    localparam logic [CODE_W-1:0] CODE_LSHIFT_BRK  = 8'hAA;
    localparam logic [CODE_W-1:0] CODE_RSHIFT_BRK  = 8'hB6;
    localparam logic [CODE_W-1:0] CODE_CTRL_MAKE   = 8'h1D;
    localparam logic [CODE_W-1:0] CODE_CTRL_BRK    = 8'h9D;
    localparam logic [CODE_W-1:0] CODE_CAPS_MAKE   = 8'h3A;
    localparam logic [CODE_W-1:0] CODE_BRK_BASE    = 8'h80;
    localparam logic [CODE_W-1:0] CODE_KEY_LIMIT   = 8'(KEY_COUNT);
    localparam logic [CODE_W-1:0] CODE_BRK_LIMIT   = 8'(8'h80 + KEY_COUNT);

    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'h7A;

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic caps;
    } mod_flags_t;

    typedef struct packed {
        logic              emit;
        logic [CHAR_W-1:0] char_code;
        logic              ctrl_flag;
        logic              shift_flag;
        logic              is_release;
    } key_event_t;

    function automatic logic [CHAR_W-1:0] plain_char(input logic [KEY_IDX_W-1:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            6'd0:  ch = 7'h00;  6'd1:  ch = 7'h1B;  6'd2:  ch = 7'h31;  6'd3:  ch = 7'h32;
            6'd4:  ch = 7'h33;  6'd5:  ch = 7'h34;  6'd6:  ch = 7'h35;  6'd7:  ch = 7'h36;
            6'd8:  ch = 7'h37;  6'd9:  ch = 7'h38;  6'd10: ch = 7'h39;  6'd11: ch = 7'h30;
            6'd12: ch = 7'h2D;  6'd13: ch = 7'h3D;  6'd14: ch = 7'h08;  6'd15: ch = 7'h09;
            6'd16: ch = 7'h71;  6'd17: ch = 7'h77;  6'd18: ch = 7'h65;  6'd19: ch = 7'h72;
            6'd20: ch = 7'h74;  6'd21: ch = 7'h79;  6'd22: ch = 7'h75;  6'd23: ch = 7'h69;
            6'd24: ch = 7'h6F;  6'd25: ch = 7'h70;  6'd26: ch = 7'h5B;  6'd27: ch = 7'h5D;
            6'd28: ch = 7'h0A;  6'd29: ch = 7'h00;  6'd30: ch = 7'h61;  6'd31: ch = 7'h73;
            6'd32: ch = 7'h64;  6'd33: ch = 7'h66;  6'd34: ch = 7'h67;  6'd35: ch = 7'h68;
            6'd36: ch = 7'h6A;  6'd37: ch = 7'h6B;  6'd38: ch = 7'h6C;  6'd39: ch = 7'h3B;
            6'd40: ch = 7'h27;  6'd41: ch = 7'h60;  6'd42: ch = 7'h00;  6'd43: ch = 7'h5C;
            6'd44: ch = 7'h7A;  6'd45: ch = 7'h78;  6'd46: ch = 7'h63;  6'd47: ch = 7'h76;
            6'd48: ch = 7'h62;  6'd49: ch = 7'h6E;  6'd50: ch = 7'h6D;  6'd51: ch = 7'h2C;
            6'd52: ch = 7'h2E;  6'd53: ch = 7'h2F;  6'd54: ch = 7'h00;  6'd55: ch = 7'h2A;
            6'd56: ch = 7'h00;  6'd57: ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] upper_char(input logic [KEY_IDX_W-1:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            6'd0:  ch = 7'h00;  6'd1:  ch = 7'h1B;  6'd2:  ch = 7'h21;  6'd3:  ch = 7'h40;
            6'd4:  ch = 7'h23;  6'd5:  ch = 7'h24;  6'd6:  ch = 7'h25;  6'd7:  ch = 7'h5E;
            6'd8:  ch = 7'h26;  6'd9:  ch = 7'h2A;  6'd10: ch = 7'h28;  6'd11: ch = 7'h29;
            6'd12: ch = 7'h5F;  6'd13: ch = 7'h2B;  6'd14: ch = 7'h08;  6'd15: ch = 7'h09;
            6'd16: ch = 7'h51;  6'd17: ch = 7'h57;  6'd18: ch = 7'h45;  6'd19: ch = 7'h52;
            6'd20: ch = 7'h54;  6'd21: ch = 7'h59;  6'd22: ch = 7'h55;  6'd23: ch = 7'h49;
            6'd24: ch = 7'h4F;  6'd25: ch = 7'h50;  6'd26: ch = 7'h7B;  6'd27: ch = 7'h7D;
            6'd28: ch = 7'h0A;  6'd29: ch = 7'h00;  6'd30: ch = 7'h41;  6'd31: ch = 7'h53;
            6'd32: ch = 7'h44;  6'd33: ch = 7'h46;  6'd34: ch = 7'h47;  6'd35: ch = 7'h48;
            6'd36: ch = 7'h4A;  6'd37: ch = 7'h4B;  6'd38: ch = 7'h4C;  6'd39: ch = 7'h3A;
            6'd40: ch = 7'h22;  6'd41: ch = 7'h7E;  6'd42: ch = 7'h00;  6'd43: ch = 7'h7C;
            6'd44: ch = 7'h5A;  6'd45: ch = 7'h58;  6'd46: ch = 7'h43;  6'd47: ch = 7'h56;
            6'd48: ch = 7'h42;  6'd49: ch = 7'h4E;  6'd50: ch = 7'h4D;  6'd51: ch = 7'h3C;
            6'd52: ch = 7'h3E;  6'd53: ch = 7'h3F;  6'd54: ch = 7'h00;  6'd55: ch = 7'h2A;
            6'd56: ch = 7'h00;  6'd57: ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: design/scancode_set1_to_ascii.sv
// Two register stages: the input register captures each accepted byte and the output
// register captures its key event, if any; both stages hold while the output is stalled.
// Throughput: one byte per cycle unless the output stalls; the input register, the table
// lookup with the modifier flag update, and the output register form one pass per byte.
// Reset clears the shift, ctrl and caps lock flags and empties both register stages.
// Depends on sc1a_pkg and sc1a_decode.
`default_nettype none

module scancode_set1_to_ascii (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [sc1a_pkg::CODE_W-1:0]        scan_byte,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [sc1a_pkg::CHAR_W-1:0]             char_code,
    output logic                                    ctrl_flag,
    output logic                                    shift_flag,
    output logic                                    is_release
);

    logic                           advance;
    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    logic [sc1a_pkg::CODE_W-1:0]    s1_byte_reg;
    sc1a_pkg::mod_flags_t           flags_reg;
    sc1a_pkg::mod_flags_t           flags_next;
    sc1a_pkg::mod_flags_t           dec_flags;
    sc1a_pkg::key_event_t           dec_evt;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    sc1a_pkg::key_event_t           out_evt_reg;

    sc1a_decode u_decode (
        .code       (s1_byte_reg),
        .flags      (flags_reg),
        .flags_next (dec_flags),
        .evt        (dec_evt)
    );

    assign advance = !out_valid_reg || !out_stall;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        flags_next     = flags_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            s1_valid_next  = in_valid;
            out_valid_next = s1_valid_reg && dec_evt.emit;
            if (s1_valid_reg)
            begin
                flags_next = dec_flags;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_byte_reg <= scan_byte;
            if (s1_valid_reg && dec_evt.emit)
            begin
                out_evt_reg <= dec_evt;
            end
        end
    end

    assign in_stall   = !advance;
    assign out_valid  = out_valid_reg;
    assign char_code  = out_evt_reg.char_code;
    assign ctrl_flag  = out_evt_reg.ctrl_flag;
    assign shift_flag = out_evt_reg.shift_flag;
    assign is_release = out_evt_reg.is_release;

endmodule

`default_nettype wire

FILE: design/sc1a_decode.sv
// Combinational decode of one scan code byte against the current modifier flags.
// Depends on sc1a_pkg for the code constants, tables and the flag and event structs.
`default_nettype none

module sc1a_decode (
    input  wire logic [sc1a_pkg::CODE_W-1:0] code,
    input  sc1a_pkg::mod_flags_t             flags,
    output sc1a_pkg::mod_flags_t             flags_next,
    output sc1a_pkg::key_event_t             evt
);

    logic [sc1a_pkg::KEY_IDX_W-1:0] key_idx;
    logic [sc1a_pkg::CHAR_W-1:0]    base_char;
    logic [sc1a_pkg::CHAR_W-1:0]    shifted_char;
    logic                           is_letter;
    logic                           use_upper;

    assign key_idx      = code[sc1a_pkg::KEY_IDX_W-1:0];
    assign base_char    = sc1a_pkg::plain_char(key_idx);
    assign shifted_char = sc1a_pkg::upper_char(key_idx);
    assign is_letter    = (base_char >= sc1a_pkg::CHAR_LOWER_A)
                       && (base_char <= sc1a_pkg::CHAR_LOWER_Z);
    assign use_upper    = flags.shift ^ (flags.caps & is_letter);

    always_comb
    begin
        flags_next = flags;
        evt        = '0;
        unique case (code) inside
            sc1a_pkg::CODE_LSHIFT_MAKE, sc1a_pkg::CODE_RSHIFT_MAKE:
            begin
                flags_next.shift = 1'b1;
            end
            sc1a_pkg::CODE_LSHIFT_BRK, sc1a_pkg::CODE_RSHIFT_BRK:
            begin
                flags_next.shift = 1'b0;
            end
            sc1a_pkg::CODE_CTRL_MAKE:
            begin
                flags_next.ctrl = 1'b1;
            end
            sc1a_pkg::CODE_CTRL_BRK:
            begin
                flags_next.ctrl = 1'b0;
            end
            sc1a_pkg::CODE_CAPS_MAKE:
            begin
                flags_next.caps = ~flags.caps;
            end
            default:
            begin
                if (code < sc1a_pkg::CODE_KEY_LIMIT)
                begin
                    evt.char_code  = use_upper ? shifted_char : base_char;
                    evt.ctrl_flag  = flags.ctrl;
                    evt.shift_flag = flags.shift;
                    evt.emit       = (evt.char_code != '0) || flags.ctrl;
                end
                else if ((code >= sc1a_pkg::CODE_BRK_BASE) && (code < sc1a_pkg::CODE_BRK_LIMIT))
                begin
                    evt.char_code  = base_char;
                    evt.is_release = 1'b1;
                    evt.emit       = (base_char != '0) || flags.ctrl;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/sc1a_checker.sv
// Port-level checks for scancode_set1_to_ascii, attached to every instance by a bind.
// Depends only on the top level's ports.
`default_nettype none

module sc1a_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [7:0] scan_byte,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [6:0] char_code,
    input wire logic       ctrl_flag,
    input wire logic       shift_flag,
    input wire logic       is_release
);

    // A release event never carries modifier flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_release |-> !ctrl_flag && !shift_flag)
        else $error("release transaction carries a modifier flag");

    // A press event without a character is only sent while ctrl is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_release && (char_code == 7'h00) |-> ctrl_flag)
        else $error("empty press transaction without ctrl");

    // The input side is held back only by a stalled output transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the output can move");

    // A stalled output transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(ctrl_flag)
            && $stable(shift_flag) && $stable(is_release))
        else $error("stalled output transaction changed");

    // A stalled input transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(scan_byte))
        else $error("stalled input transaction changed");

endmodule

bind scancode_set1_to_ascii sc1a_checker u_sc1a_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .scan_byte  (scan_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_code  (char_code),
    .ctrl_flag  (ctrl_flag),
    .shift_flag (shift_flag),
    .is_release (is_release)
);

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for scancode_set1_to_ascii: drives scan code bytes, predicts
// each key event from its own modifier state and character maps, and checks the outputs.
// Depends on sc1a_pkg and the scancode_set1_to_ascii RTL.

module testbench;

    localparam int unsigned CODE_W = sc1a_pkg::CODE_W;
    localparam int unsigned CHAR_W = sc1a_pkg::CHAR_W;
    localparam int FEED_DRAIN = -1;
    localparam int RANDOM_BYTES = 800;
    localparam int HOLD_CYCLES = 40;
    localparam int HOLD_AFTER = 100;
    localparam int CALM_TAIL = 120;
    localparam int IDLE_LIMIT = 2000;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              ctrl;
        logic              shift;
        logic              rel;
    } tb_event_t;

    byte unsigned lower_map [sc1a_pkg::KEY_COUNT] = '{
        8'd0, 8'd27, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'd8,
        8'd9, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'd10,
        8'd0, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'd39, 8'd96, 8'd0,
        8'd92, "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'd0, "*", 8'd0, " "
    };

    byte unsigned upper_map [sc1a_pkg::KEY_COUNT] = '{
        8'd0, 8'd27, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'd8,
        8'd9, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'd10,
        8'd0, "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'd34, "~", 8'd0,
        "|", "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'd0, "*", 8'd0, " "
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [CODE_W-1:0] scan_byte = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CHAR_W-1:0] char_code;
    logic              ctrl_flag;
    logic              shift_flag;
    logic              is_release;

    int         scan_feed[$];
    tb_event_t  awaited_events[$];

    logic shift_down = 1'b0;
    logic ctrl_down = 1'b0;
    logic caps_latched = 1'b0;

    int         fault_count = 0;
    int         events_seen = 0;
    int         idle_cycles = 0;
    int         send_gap_left = 0;
    int         send_gap_pct = 0;
    int         send_cycle = 0;
    int         recv_stall_left = 0;
    int         recv_stall_pct = 0;
    int         recv_cycle = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    bit         next_valid;
    bit         next_stall;
    bit         wind_down;
    tb_event_t  seen_event;
    tb_event_t  want_event;

    scancode_set1_to_ascii i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .scan_byte  (scan_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .char_code  (char_code),
        .ctrl_flag  (ctrl_flag),
        .shift_flag (shift_flag),
        .is_release (is_release)
    );

    always #5 clk = ~clk;

    function automatic void decode_scan_byte(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0]              base;
        logic [CHAR_W-1:0]              ch;
        logic                           use_upper;
        logic [sc1a_pkg::KEY_IDX_W-1:0] idx;
        tb_event_t                      ev;
        if (code == sc1a_pkg::CODE_LSHIFT_MAKE || code == sc1a_pkg::CODE_RSHIFT_MAKE)
        begin
            shift_down = 1'b1;
        end
        else if (code == sc1a_pkg::CODE_LSHIFT_BRK || code == sc1a_pkg::CODE_RSHIFT_BRK)
        begin
            shift_down = 1'b0;
        end
        else if (code == sc1a_pkg::CODE_CTRL_MAKE)
        begin
            ctrl_down = 1'b1;
        end
        else if (code == sc1a_pkg::CODE_CTRL_BRK)
        begin
            ctrl_down = 1'b0;
        end
        else if (code == sc1a_pkg::CODE_CAPS_MAKE)
        begin
            caps_latched = !caps_latched;
        end
        else if (code < sc1a_pkg::CODE_KEY_LIMIT)
        begin
            idx = code[sc1a_pkg::KEY_IDX_W-1:0];
            base = lower_map[idx][CHAR_W-1:0];
            use_upper = shift_down;
            if (caps_latched && base >= sc1a_pkg::CHAR_LOWER_A
                && base <= sc1a_pkg::CHAR_LOWER_Z)
            begin
                use_upper = !use_upper;
            end
            ch = use_upper ? upper_map[idx][CHAR_W-1:0] : base;
            if (ch != '0 || ctrl_down)
            begin
                ev.char_code = ch;
                ev.ctrl = ctrl_down;
                ev.shift = shift_down;
                ev.rel = 1'b0;
                awaited_events.push_back(ev);
            end
        end
        else if (code >= sc1a_pkg::CODE_BRK_BASE && code < sc1a_pkg::CODE_BRK_LIMIT)
        begin
            idx = sc1a_pkg::KEY_IDX_W'(code - sc1a_pkg::CODE_BRK_BASE);
            ch = lower_map[idx][CHAR_W-1:0];
            if (ch != '0 || ctrl_down)
            begin
                ev.char_code = ch;
                ev.ctrl = 1'b0;
                ev.shift = 1'b0;
                ev.rel = 1'b1;
                awaited_events.push_back(ev);
            end
        end
    endfunction

    function automatic int pick_idle_pct();
        int pct;
        case ($urandom_range(0, 2))
            0: pct = 0;
            1: pct = 12;
            default: pct = 40;
        endcase
        return pct;
    endfunction

    function automatic void feed_byte(input logic [CODE_W-1:0] code);
        scan_feed.push_back(int'(code));
    endfunction

    function automatic void build_directed();
        feed_byte(8'h00);
        feed_byte(8'hFF);
        feed_byte(8'h10);
        feed_byte(sc1a_pkg::CODE_LSHIFT_MAKE);
        feed_byte(8'h10);
        feed_byte(8'h03);
        feed_byte(sc1a_pkg::CODE_LSHIFT_BRK);
        feed_byte(sc1a_pkg::CODE_CAPS_MAKE);
        feed_byte(8'h10);
        feed_byte(sc1a_pkg::CODE_RSHIFT_MAKE);
        feed_byte(8'h10);
        feed_byte(8'h03);
        feed_byte(sc1a_pkg::CODE_RSHIFT_BRK);
        feed_byte(sc1a_pkg::CODE_CAPS_MAKE);
        feed_byte(sc1a_pkg::CODE_CTRL_MAKE);
        feed_byte(8'h2E);
        feed_byte(8'h00);
        feed_byte(sc1a_pkg::CODE_BRK_BASE);
        feed_byte(8'hAE);
        feed_byte(sc1a_pkg::CODE_CTRL_BRK);
        feed_byte(8'hBA);
        feed_byte(8'h39);
        feed_byte(8'h3B);
        feed_byte(8'h7F);
        feed_byte(8'hB9);
        scan_feed.push_back(FEED_DRAIN);
    endfunction

    function automatic void build_random();
        int                placed;
        int                mark;
        int                roll;
        bit                with_shift;
        bit                with_ctrl;
        logic [CODE_W-1:0] key;
        logic [CODE_W-1:0] extra;
        placed = 0;
        mark = 0;
        while (placed < RANDOM_BYTES)
        begin
            mark = scan_feed.size();
            roll = $urandom_range(0, 99);
            if (roll < 60)
            begin
                with_shift = ($urandom_range(0, 2) == 0);
                with_ctrl = ($urandom_range(0, 4) == 0);
                key = CODE_W'($urandom_range(0, sc1a_pkg::KEY_COUNT - 1));
                if (with_shift)
                begin
                    feed_byte($urandom_range(0, 1) ? sc1a_pkg::CODE_LSHIFT_MAKE
                                                   : sc1a_pkg::CODE_RSHIFT_MAKE);
                end
                if (with_ctrl)
                begin
                    feed_byte(sc1a_pkg::CODE_CTRL_MAKE);
                end
                feed_byte(key);
                if ($urandom_range(0, 3) == 0)
                begin
                    extra = CODE_W'($urandom_range(0, sc1a_pkg::KEY_COUNT - 1));
                    feed_byte(extra);
                    feed_byte(extra | sc1a_pkg::CODE_BRK_BASE);
                end
                feed_byte(key | sc1a_pkg::CODE_BRK_BASE);
                if (with_ctrl)
                begin
                    feed_byte(sc1a_pkg::CODE_CTRL_BRK);
                end
                if (with_shift)
                begin
                    feed_byte($urandom_range(0, 1) ? sc1a_pkg::CODE_LSHIFT_BRK
                                                   : sc1a_pkg::CODE_RSHIFT_BRK);
                end
            end
            else if (roll < 70)
            begin
                feed_byte(sc1a_pkg::CODE_CAPS_MAKE);
                if ($urandom_range(0, 1) == 0)
                begin
                    feed_byte(sc1a_pkg::CODE_CAPS_MAKE | sc1a_pkg::CODE_BRK_BASE);
                end
            end
            else if (roll < 85)
            begin
                feed_byte(CODE_W'($urandom_range(0, 255)));
            end
            else if (roll < 93)
            begin
                feed_byte(CODE_W'($urandom_range(0, sc1a_pkg::KEY_COUNT - 1))
                          | sc1a_pkg::CODE_BRK_BASE);
            end
            else
            begin
                feed_byte(CODE_W'($urandom_range(0, sc1a_pkg::KEY_COUNT - 1)));
            end
            if (placed < RANDOM_BYTES / 2 && placed + scan_feed.size() - mark >= RANDOM_BYTES / 2)
            begin
                scan_feed.push_back(FEED_DRAIN);
            end
            placed = placed + scan_feed.size() - mark;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                decode_scan_byte(scan_byte);
            end
            if (send_cycle % 64 == 0)
            begin
                send_gap_pct = pick_idle_pct();
            end
            send_cycle++;
            wind_down = (scan_feed.size() < CALM_TAIL);
            next_valid = 1'b0;
            if (in_valid && in_stall)
            begin
                next_valid = 1'b1;
            end
            else if (send_gap_left > 0)
            begin
                send_gap_left--;
            end
            else if (!wind_down && $urandom_range(0, 99) < send_gap_pct)
            begin
                send_gap_left = $urandom_range(0, 7);
            end
            else
            begin
                while (scan_feed.size() > 0 && scan_feed[0] == FEED_DRAIN
                       && awaited_events.size() == 0)
                begin
                    void'(scan_feed.pop_front());
                end
                if (scan_feed.size() > 0 && scan_feed[0] != FEED_DRAIN)
                begin
                    next_valid = 1'b1;
                    scan_byte <= CODE_W'(scan_feed.pop_front());
                end
            end
            in_valid <= next_valid;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                events_seen++;
                seen_event.char_code = char_code;
                seen_event.ctrl = ctrl_flag;
                seen_event.shift = shift_flag;
                seen_event.rel = is_release;
                if (awaited_events.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                    begin
                        $display("Unexpected key event: char %h ctrl %b shift %b release %b",
                                 char_code, ctrl_flag, shift_flag, is_release);
                    end
                end
                else
                begin
                    want_event = awaited_events.pop_front();
                    if (seen_event.char_code !== want_event.char_code
                        || seen_event.ctrl !== want_event.ctrl
                        || seen_event.shift !== want_event.shift
                        || seen_event.rel !== want_event.rel)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_MAX)
                        begin
                            $display("Key event mismatch: expected char %h ctrl %b shift %b %s",
                                     want_event.char_code, want_event.ctrl, want_event.shift,
                                     $sformatf("release %b, got char %h ctrl %b shift %b release %b",
                                               want_event.rel, char_code, ctrl_flag,
                                               shift_flag, is_release));
                        end
                    end
                end
            end
            if (recv_cycle % 64 == 0)
            begin
                recv_stall_pct = pick_idle_pct();
            end
            recv_cycle++;
            next_stall = 1'b0;
            if (hold_left > 0)
            begin
                hold_left--;
                next_stall = 1'b1;
            end
            else if (!hold_done && events_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                next_stall = 1'b1;
            end
            else if (recv_stall_left > 0)
            begin
                recv_stall_left--;
                next_stall = 1'b1;
            end
            else if (scan_feed.size() >= CALM_TAIL && $urandom_range(0, 99) < recv_stall_pct)
            begin
                recv_stall_left = $urandom_range(0, 7);
                next_stall = 1'b1;
            end
            out_stall <= next_stall;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        build_directed();
        build_random();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (scan_feed.size() > 0 || in_valid || awaited_events.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/sc1a_pkg.sv
design/sc1a_decode.sv
design/scancode_set1_to_ascii.sv
design/sc1a_checker.sv
bench/testbench.sv
